/* rtl/sbs_pkg.sv */
// Shared types and codes for the sorted table binary search block.
`timescale 1ns / 1ps

package sbs_pkg;

	localparam int unsigned COUNT_W = 9;
	localparam int unsigned INDEX_W = 8;
	localparam int unsigned DATA_W  = 32;

	localparam logic ACT_WRITE  = 1'b0;
	localparam logic ACT_SEARCH = 1'b1;

	typedef struct packed {
		logic                     action;
		logic [INDEX_W-1:0]       entry_index;
		logic signed [DATA_W-1:0] value;
	} sbs_in_t;

	typedef struct packed {
		logic               found;
		logic [INDEX_W-1:0] position;
	} sbs_out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_CMP
	} sbs_state_t;

endpackage

/* rtl/sorted_table_binary_search.sv */
// Top level of the sorted table binary search block.
// Usage:
//  - Input words: req is taken at a rising edge with start high and busy low.
//    action write stores req.value at req.entry_index (ignored when the index
//    is not below TABLE_DEPTH) and gives no result; busy stays low.
//  - action search looks for req.value among entries 0..entry_count-1,
//    entry_count clamped to TABLE_DEPTH. Entries must be written and sorted
//    ascending beforehand.
//  - Result word: rsp is valid for exactly one cycle with done high; the
//    receiver cannot stall it. position is 0 when found is 0.
//  - Sequence: busy is high for a READ and a CMP state per table probe on a hit
//    and one more READ on a miss; done is high in the first cycle with busy
//    low, so the next word can be taken at the edge that takes the result. At
//    most floor(log2(count))+1 probes. Each probe reads through the single
//    read port of the table memory, whose registered read data is compared in CMP.
//  - Config: cfg_data loads entry_count when cfg_valid is high; cfg_ready
//    is always high. Write it only while busy is low.
//  - Reset: arst_n clears the sequencer and sets entry_count to 0; table
//    contents stay undefined until written.
`timescale 1ns / 1ps

module sorted_table_binary_search #(
	parameter int unsigned TABLE_DEPTH = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  sbs_pkg::sbs_in_t            req,
	output logic                        done,
	output sbs_pkg::sbs_out_t           rsp,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [sbs_pkg::COUNT_W-1:0] cfg_data
);

	localparam int unsigned ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	logic [sbs_pkg::COUNT_W-1:0]       entry_count_q;
	logic                              mem_wr_en;
	logic [ADDR_W-1:0]                 mem_wr_addr;
	logic signed [sbs_pkg::DATA_W-1:0] mem_wr_data;
	logic                              mem_rd_en;
	logic [ADDR_W-1:0]                 mem_rd_addr;
	logic signed [sbs_pkg::DATA_W-1:0] mem_rd_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			entry_count_q <= cfg_data;
		end
	end

	sbs_ctrl #(
		.DEPTH  (TABLE_DEPTH),
		.ADDR_W (ADDR_W)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req         (req),
		.done        (done),
		.rsp         (rsp),
		.entry_count (entry_count_q),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data),
		.mem_rd_en   (mem_rd_en),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data)
	);

	sbs_mem #(
		.DEPTH  (TABLE_DEPTH),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

endmodule

/* rtl/sbs_mem.sv */
// Table storage: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module sbs_mem #(
	parameter int unsigned DEPTH  = 256,
	parameter int unsigned ADDR_W = 8
) (
	input  logic                             clk,
	input  logic                             wr_en,
	input  logic [ADDR_W-1:0]                wr_addr,
	input  logic signed [sbs_pkg::DATA_W-1:0] wr_data,
	input  logic                             rd_en,
	input  logic [ADDR_W-1:0]                rd_addr,
	output logic signed [sbs_pkg::DATA_W-1:0] rd_data
);

	logic signed [sbs_pkg::DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* rtl/sbs_ctrl.sv */
// Search sequencer: takes words, writes entries, walks low/high over the table.
`timescale 1ns / 1ps

module sbs_ctrl #(
	parameter int unsigned DEPTH  = 256,
	parameter int unsigned ADDR_W = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  sbs_pkg::sbs_in_t                  req,
	output logic                              done,
	output sbs_pkg::sbs_out_t                 rsp,
	input  logic [sbs_pkg::COUNT_W-1:0]       entry_count,
	output logic                              mem_wr_en,
	output logic [ADDR_W-1:0]                 mem_wr_addr,
	output logic signed [sbs_pkg::DATA_W-1:0] mem_wr_data,
	output logic                              mem_rd_en,
	output logic [ADDR_W-1:0]                 mem_rd_addr,
	input  logic signed [sbs_pkg::DATA_W-1:0] mem_rd_data
);

	// low and high+1 both range over 0..DEPTH
	localparam int unsigned CW = $clog2(DEPTH + 1);

	sbs_pkg::sbs_state_t state_q, state_d;

	logic [CW-1:0]                     low_q, low_d;
	logic [CW-1:0]                     hp_q, hp_d;
	logic [ADDR_W-1:0]                 mid_q, mid_d;
	logic signed [sbs_pkg::DATA_W-1:0] target_q, target_d;
	logic                              done_q, done_d;
	sbs_pkg::sbs_out_t                 rsp_q, rsp_d;

	logic [CW:0]   mid_sum;
	logic [CW-1:0] mid_full;
	logic [CW-1:0] count_eff;
	logic [31:0]   wr_idx_ext;
	logic          accept;

	assign accept     = start && (state_q == sbs_pkg::ST_IDLE);
	assign wr_idx_ext = 32'(req.entry_index);

	// floor((low + high) / 2) with high = hp - 1; only used while low < hp
	assign mid_sum  = {1'b0, low_q} + {1'b0, hp_q} - (CW+1)'(1);
	assign mid_full = mid_sum[CW:1];

	always_comb begin
		if (32'(entry_count) > DEPTH) begin
			count_eff = CW'(DEPTH);
		end else begin
			count_eff = CW'(entry_count);
		end
	end

	assign mem_wr_en   = accept && (req.action == sbs_pkg::ACT_WRITE) && (wr_idx_ext < DEPTH);
	assign mem_wr_addr = wr_idx_ext[ADDR_W-1:0];
	assign mem_wr_data = req.value;
	assign mem_rd_addr = mid_full[ADDR_W-1:0];

	always_comb begin
		state_d   = state_q;
		low_d     = low_q;
		hp_d      = hp_q;
		mid_d     = mid_q;
		target_d  = target_q;
		done_d    = 1'b0;
		rsp_d     = rsp_q;
		mem_rd_en = 1'b0;
		case (state_q)
			sbs_pkg::ST_IDLE: begin
				if (accept && (req.action == sbs_pkg::ACT_SEARCH)) begin
					target_d = req.value;
					low_d    = '0;
					hp_d     = count_eff;
					state_d  = sbs_pkg::ST_READ;
				end
			end
			sbs_pkg::ST_READ: begin
				if (low_q < hp_q) begin
					mem_rd_en = 1'b1;
					mid_d     = mid_full[ADDR_W-1:0];
					state_d   = sbs_pkg::ST_CMP;
				end else begin
					done_d         = 1'b1;
					rsp_d.found    = 1'b0;
					rsp_d.position = '0;
					state_d        = sbs_pkg::ST_IDLE;
				end
			end
			sbs_pkg::ST_CMP: begin
				if (mem_rd_data < target_q) begin
					low_d   = CW'(mid_q) + CW'(1);
					state_d = sbs_pkg::ST_READ;
				end else if (mem_rd_data > target_q) begin
					hp_d    = CW'(mid_q);
					state_d = sbs_pkg::ST_READ;
				end else begin
					done_d         = 1'b1;
					rsp_d.found    = 1'b1;
					rsp_d.position = 8'(mid_q);
					state_d        = sbs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sbs_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sbs_pkg::ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		low_q    <= low_d;
		hp_q     <= hp_d;
		mid_q    <= mid_d;
		target_q <= target_d;
		rsp_q    <= rsp_d;
	end

	assign busy = (state_q != sbs_pkg::ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
